// ===== src/segment_display_serial_writer_assert.svh =====
// assertion macros used by the segment display writer back end (ssw_back)
// no dependencies; included by ssw_back, which carries concurrent checks
`ifndef SEGMENT_DISPLAY_SERIAL_WRITER_ASSERT_SVH
`define SEGMENT_DISPLAY_SERIAL_WRITER_ASSERT_SVH
`ifndef SYNTHESIS
// check sampled on clk, skipped while reset is asserted
`define SSW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check sampled on clk, also active during reset
`define SSW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SSW_ASSERT(lbl, prop, msg)
`define SSW_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== src/ssw_pkg.sv =====
// shared types and constants of the segment display writer
// no dependencies; used by the top level, front, queue, back and the dv files
`timescale 1ns / 1ps
package ssw_pkg;

  // kind of one input beat
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SEND = 1'b1
  } op_kind_t;

  // transaction stage of the wire sequencer
  typedef enum logic [1:0] {
    STG_IDLE = 2'd0,
    STG_DATA = 2'd1,
    STG_ADDR = 2'd2,
    STG_CTRL = 2'd3
  } stage_t;

  // bit slot codes inside one transaction
  localparam logic [3:0] SLOT_START    = 4'd0;
  localparam logic [3:0] SLOT_DATA_END = 4'd8;
  localparam logic [3:0] SLOT_ACK      = 4'd9;
  localparam logic [3:0] SLOT_STOP     = 4'd10;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_CMD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_CMD    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_CMD    = 3'd4;

  localparam int NUM_INPUT_DIGITS = 4;
  localparam int SLOT_W = 3;

  // classified beat handed from front to back
  typedef struct packed {
    op_kind_t                              kind;
    logic [NUM_INPUT_DIGITS-1:0][7:0]      digits;
    logic [SLOT_W-1:0]                     count;
    logic [1:0]                            position;
    logic                                  sense;
  } op_t;

  // configuration register set
  typedef struct packed {
    logic [3:0] brightness;
    logic [7:0] ticks;
    logic [7:0] data_cmd;
    logic [7:0] addr_cmd;
    logic [7:0] ctrl_cmd;
  } cfg_t;

endpackage

// ===== src/ssw_in_if.sv =====
// input channel of the segment display writer: valid, ready and beat fields
// no dependencies
`timescale 1ns / 1ps
interface ssw_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] digit0;
  logic [7:0] digit1;
  logic [7:0] digit2;
  logic [7:0] digit3;
  logic [2:0] digit_count;
  logic [1:0] first_position;
  logic       dio_sense;

  modport source (
    output valid, command, digit0, digit1, digit2, digit3,
           digit_count, first_position, dio_sense,
    input  ready
  );
  modport sink (
    input  valid, command, digit0, digit1, digit2, digit3,
           digit_count, first_position, dio_sense,
    output ready
  );
endinterface

// ===== src/ssw_out_if.sv =====
// result channel of the segment display writer: valid, ready and line levels
// no dependencies
`timescale 1ns / 1ps
interface ssw_out_if;
  logic valid;
  logic ready;
  logic clk_low;
  logic dio_low;
  logic busy_res;

  modport source (output valid, clk_low, dio_low, busy_res, input ready);
  modport sink (input valid, clk_low, dio_low, busy_res, output ready);
endinterface

// ===== src/segment_display_serial_writer.sv =====
// top level of the two-wire segment display writer
// depends on ssw_pkg, ssw_in_if, ssw_out_if, ssw_front, ssw_queue, ssw_back
//
//  channel | dir | handshake     | payload
//  in_bus  | in  | valid / ready | command, digit0..3, digit_count, first_position, dio_sense
//  out_bus | out | valid / ready | clk_low, dio_low, busy_res
//  cfg     | in  | cfg_we        | cfg_index, cfg_data
//
// one beat per cycle while results are taken; a beat passes the queue and the result register
// front writes a two-entry queue; the sequencer pops one beat a cycle unless the result stalls
// a stalled result only stops the sequencer; input stalls once the queue is full
// synchronous active-low reset: idle, both lines released, registers at defaults
`timescale 1ns / 1ps
module segment_display_serial_writer #(
  parameter int MAX_DIGITS = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ssw_in_if.sink                        in_bus,
  ssw_out_if.source                     out_bus,
  input  logic                          cfg_we,
  input  logic [ssw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);

  ssw_pkg::cfg_t cfg_r;
  ssw_pkg::op_t  push_op;
  ssw_pkg::op_t  pop_op;
  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.brightness <= 4'd15;
      cfg_r.ticks      <= 8'd100;
      cfg_r.data_cmd   <= 8'h40;
      cfg_r.addr_cmd   <= 8'hC0;
      cfg_r.ctrl_cmd   <= 8'h80;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ssw_pkg::CFG_BRIGHTNESS: cfg_r.brightness <= cfg_data[3:0];
        ssw_pkg::CFG_TICKS:      cfg_r.ticks      <= cfg_data;
        ssw_pkg::CFG_DATA_CMD:   cfg_r.data_cmd   <= cfg_data;
        ssw_pkg::CFG_ADDR_CMD:   cfg_r.addr_cmd   <= cfg_data;
        ssw_pkg::CFG_CTRL_CMD:   cfg_r.ctrl_cmd   <= cfg_data;
        default: ;
      endcase
    end
  end

  // accept and classify
  ssw_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
    .in_bus (in_bus),
    .q_full (q_full),
    .q_push (q_push),
    .q_op   (push_op)
  );

  // decoupling queue
  ssw_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (q_pop),
    .pop_op  (pop_op),
    .empty   (q_empty)
  );

  // wire sequencer and result
  ssw_back #(.MAX_DIGITS(MAX_DIGITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .op      (pop_op),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_bus (out_bus)
  );

endmodule

// ===== src/ssw_front.sv =====
// front end: accepts input beats, classifies them and clamps the digit count
// depends on ssw_pkg and ssw_in_if
`timescale 1ns / 1ps
module ssw_front #(
  parameter int MAX_DIGITS = 4
) (
  ssw_in_if.sink         in_bus,
  input  logic           q_full,
  output logic           q_push,
  output ssw_pkg::op_t   q_op
);

  // accept whenever the queue has room
  assign in_bus.ready = !q_full;
  assign q_push       = in_bus.valid && !q_full;

  // classify the beat and clamp the count
  always_comb begin
    q_op.kind      = in_bus.command ? ssw_pkg::OP_SEND : ssw_pkg::OP_TICK;
    q_op.digits    = {in_bus.digit3, in_bus.digit2, in_bus.digit1, in_bus.digit0};
    q_op.count     = (in_bus.digit_count > ssw_pkg::SLOT_W'(MAX_DIGITS))
                     ? ssw_pkg::SLOT_W'(MAX_DIGITS) : in_bus.digit_count;
    q_op.position  = in_bus.first_position;
    q_op.sense     = in_bus.dio_sense;
  end

endmodule

// ===== src/ssw_queue.sv =====
// two-entry queue of classified beats between front and back
// depends on ssw_pkg
`timescale 1ns / 1ps
module ssw_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ssw_pkg::op_t  push_op,
  output logic          full,
  input  logic          pop,
  output ssw_pkg::op_t  pop_op,
  output logic          empty
);

  ssw_pkg::op_t entry_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   count_r;

  assign full   = (count_r == 2'd2);
  assign empty  = (count_r == 2'd0);
  assign pop_op = entry_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== src/ssw_back.sv =====
// back end: prescaler, wire sequencer and result register
// depends on ssw_pkg, ssw_out_if and the assertion header
`timescale 1ns / 1ps
`include "segment_display_serial_writer_assert.svh"
module ssw_back #(
  parameter int MAX_DIGITS = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ssw_pkg::cfg_t cfg,
  input  ssw_pkg::op_t  op,
  input  logic          q_empty,
  output logic          q_pop,
  ssw_out_if.source     out_bus
);

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  // sequencer state
  ssw_pkg::stage_t          stage_r, stage_nxt;
  logic [ssw_pkg::SLOT_W-1:0] byte_slot_r, byte_slot_nxt;
  logic [ssw_pkg::SLOT_W-1:0] total_r, total_nxt;
  logic [1:0]               pos_r, pos_nxt;
  logic [3:0]               bit_slot_r, bit_slot_nxt;
  logic [2:0]               phase_r, phase_nxt;
  logic [7:0]               shift_r, shift_nxt;
  logic [7:0]               tick_r, tick_nxt;
  logic                     clk_low_r, clk_low_nxt;
  logic                     dio_low_r, dio_low_nxt;
  logic [7:0]               frame_r [MAX_DIGITS];
  logic                     load_frame;

  // result register
  logic out_valid_r;
  logic out_clk_r;
  logic out_dio_r;
  logic out_busy_r;

  logic [7:0]               limit;
  logic [ssw_pkg::SLOT_W-1:0] sel_slot;
  logic [ssw_pkg::SLOT_W-1:0] sel_m1;
  logic [7:0]               cur_byte;
  logic [2:0]               phase_inc;
  logic                     do_apply;

  // take a beat when the result register is free or being emptied
  assign q_pop = !q_empty && (!out_valid_r || out_bus.ready);

  assign limit     = (cfg.ticks == 8'd0) ? 8'd1 : cfg.ticks;
  assign phase_inc = phase_r + 3'd1;

  // byte that the next data bits will shift out
  assign sel_slot = (bit_slot_r == ssw_pkg::SLOT_START) ? '0 : byte_slot_r + 1'b1;
  assign sel_m1   = sel_slot - 1'b1;
  always_comb begin
    if (stage_r == ssw_pkg::STG_DATA) begin
      cur_byte = cfg.data_cmd;
    end else if (stage_r == ssw_pkg::STG_ADDR) begin
      if (sel_slot == '0) begin
        cur_byte = cfg.addr_cmd + {6'd0, pos_r};
      end else if (sel_slot <= ssw_pkg::SLOT_W'(MAX_DIGITS)) begin
        cur_byte = frame_r[sel_m1[IDX_W-1:0]];
      end else begin
        cur_byte = 8'd0;
      end
    end else begin
      cur_byte = cfg.ctrl_cmd + {4'd0, cfg.brightness};
    end
  end

  // next state: send latch, prescaler, sequencer step and line action
  always_comb begin
    stage_nxt     = stage_r;
    byte_slot_nxt = byte_slot_r;
    total_nxt     = total_r;
    pos_nxt       = pos_r;
    bit_slot_nxt  = bit_slot_r;
    phase_nxt     = phase_r;
    shift_nxt     = shift_r;
    tick_nxt      = tick_r;
    clk_low_nxt   = clk_low_r;
    dio_low_nxt   = dio_low_r;
    load_frame    = 1'b0;
    do_apply      = 1'b0;

    if (q_pop) begin
      if (op.kind == ssw_pkg::OP_SEND) begin
        if (stage_r == ssw_pkg::STG_IDLE) begin
          load_frame    = 1'b1;
          total_nxt     = op.count;
          pos_nxt       = op.position;
          stage_nxt     = ssw_pkg::STG_DATA;
          byte_slot_nxt = '0;
          bit_slot_nxt  = ssw_pkg::SLOT_START;
          phase_nxt     = 3'd0;
          shift_nxt     = 8'd0;
          tick_nxt      = 8'd0;
          do_apply      = 1'b1;
        end
      end else if (stage_r != ssw_pkg::STG_IDLE) begin
        tick_nxt = tick_r + 8'd1;
        if (tick_nxt >= limit) begin
          tick_nxt = 8'd0;
          // sequencer step
          if (bit_slot_r == ssw_pkg::SLOT_START) begin
            bit_slot_nxt  = 4'd1;
            phase_nxt     = 3'd0;
            byte_slot_nxt = '0;
            shift_nxt     = cur_byte;
          end else if (bit_slot_r <= ssw_pkg::SLOT_DATA_END) begin
            phase_nxt = phase_inc;
            if (phase_inc >= 3'd3) begin
              phase_nxt    = 3'd0;
              shift_nxt    = {1'b0, shift_r[7:1]};
              bit_slot_nxt = bit_slot_r + 4'd1;
            end
          end else if (bit_slot_r == ssw_pkg::SLOT_ACK) begin
            phase_nxt = phase_inc;
            if (phase_inc >= 3'd4) begin
              phase_nxt = 3'd0;
              if (stage_r == ssw_pkg::STG_ADDR && byte_slot_r < total_r) begin
                byte_slot_nxt = sel_slot;
                shift_nxt     = cur_byte;
                bit_slot_nxt  = 4'd1;
              end else begin
                bit_slot_nxt = ssw_pkg::SLOT_STOP;
              end
            end
          end else begin
            phase_nxt = phase_inc;
            if (phase_inc >= 3'd3) begin
              phase_nxt     = 3'd0;
              byte_slot_nxt = '0;
              bit_slot_nxt  = ssw_pkg::SLOT_START;
              unique case (stage_r)
                ssw_pkg::STG_IDLE: stage_nxt = ssw_pkg::STG_DATA;
                ssw_pkg::STG_DATA: stage_nxt = ssw_pkg::STG_ADDR;
                ssw_pkg::STG_ADDR: stage_nxt = ssw_pkg::STG_CTRL;
                ssw_pkg::STG_CTRL: stage_nxt = ssw_pkg::STG_IDLE;
                default:           stage_nxt = ssw_pkg::STG_IDLE;
              endcase
            end
          end
          do_apply = (stage_nxt != ssw_pkg::STG_IDLE);
        end
      end
    end

    // line action for the slot and phase just entered
    if (do_apply) begin
      if (bit_slot_nxt == ssw_pkg::SLOT_START) begin
        dio_low_nxt = 1'b1;
      end else if (bit_slot_nxt <= ssw_pkg::SLOT_DATA_END) begin
        if (phase_nxt == 3'd0) begin
          clk_low_nxt = 1'b1;
        end else if (phase_nxt == 3'd1) begin
          dio_low_nxt = !shift_nxt[0];
        end else begin
          clk_low_nxt = 1'b0;
        end
      end else if (bit_slot_nxt == ssw_pkg::SLOT_ACK) begin
        if (phase_nxt == 3'd0) begin
          clk_low_nxt = 1'b1;
          dio_low_nxt = 1'b0;
        end else if (phase_nxt == 3'd1) begin
          clk_low_nxt = 1'b0;
        end else if (phase_nxt == 3'd2) begin
          if (!op.sense) begin
            dio_low_nxt = 1'b1;
          end
        end else begin
          clk_low_nxt = 1'b1;
        end
      end else begin
        if (phase_nxt == 3'd0) begin
          dio_low_nxt = 1'b1;
        end else if (phase_nxt == 3'd1) begin
          clk_low_nxt = 1'b0;
        end else begin
          dio_low_nxt = 1'b0;
        end
      end
    end
  end

  // segment bytes of the frame, slots past the input digits read as zero
  always_ff @(posedge clk) begin
    if (load_frame) begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
        frame_r[i] <= (i < ssw_pkg::NUM_INPUT_DIGITS) ? op.digits[i] : 8'd0;
      end
    end
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r     <= ssw_pkg::STG_IDLE;
      byte_slot_r <= '0;
      total_r     <= '0;
      pos_r       <= 2'd0;
      bit_slot_r  <= ssw_pkg::SLOT_START;
      phase_r     <= 3'd0;
      shift_r     <= 8'd0;
      tick_r      <= 8'd0;
      clk_low_r   <= 1'b0;
      dio_low_r   <= 1'b0;
    end else begin
      stage_r     <= stage_nxt;
      byte_slot_r <= byte_slot_nxt;
      total_r     <= total_nxt;
      pos_r       <= pos_nxt;
      bit_slot_r  <= bit_slot_nxt;
      phase_r     <= phase_nxt;
      shift_r     <= shift_nxt;
      tick_r      <= tick_nxt;
      clk_low_r   <= clk_low_nxt;
      dio_low_r   <= dio_low_nxt;
    end
  end

  // result register, one beat per popped item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_clk_r  <= clk_low_nxt;
      out_dio_r  <= dio_low_nxt;
      out_busy_r <= (stage_nxt != ssw_pkg::STG_IDLE);
    end
  end

  assign out_bus.valid    = out_valid_r;
  assign out_bus.clk_low  = out_clk_r;
  assign out_bus.dio_low  = out_dio_r;
  assign out_bus.busy_res = out_busy_r;

  // checks
  `SSW_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> stage_r == ssw_pkg::STG_IDLE && !clk_low_r && !dio_low_r, "reset left a line low")
  `SSW_ASSERT(a_idle_released, (stage_r != ssw_pkg::STG_IDLE) || (!clk_low_r && !dio_low_r), "idle with a line low")
  `SSW_ASSERT(a_hold_without_pop, !q_pop |=> $stable(stage_r) && $stable(bit_slot_r) && $stable(tick_r), "moved without a beat")
  `SSW_ASSERT(a_send_starts, q_pop && op.kind == ssw_pkg::OP_SEND && stage_r == ssw_pkg::STG_IDLE |=> stage_r == ssw_pkg::STG_DATA && dio_low_r && out_busy_r, "no frame start")
  `SSW_ASSERT(a_busy_matches, q_pop |=> out_busy_r == (stage_r != ssw_pkg::STG_IDLE), "busy differs from stage")

endmodule

// ===== dv/segment_display_serial_writer_checker.sv =====
// result checker for the segment display writer: tracks the wire sequencer beat by beat
// depends on ssw_pkg, ssw_in_if and ssw_out_if; instantiated by segment_display_serial_writer_tb
`timescale 1ns / 1ps
module segment_display_serial_writer_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  ssw_in_if                             in_mon,
  ssw_out_if                            out_mon,
  input  logic                          cfg_we,
  input  logic [ssw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  output int                            fail_count,
  output int                            pending_results,
  output int                            live_beats,
  output logic                          writer_idle
);

  localparam logic [2:0] MAX_SEGMENTS = 3'd4;

  typedef struct packed {
    logic clk_low;
    logic dio_low;
    logic busy;
  } line_levels_t;

  // shadow of the register set and the sequencer state
  ssw_pkg::cfg_t   regs;
  logic [7:0]      seg_bytes [4];
  logic [2:0]      seg_total;
  logic [1:0]      pos_latch;
  ssw_pkg::stage_t stage;
  logic [2:0]      byte_idx;
  logic [3:0]      bit_idx;
  logic [2:0]      step_idx;
  logic [7:0]      shifter;
  logic [7:0]      tick_cnt;
  logic            clk_pull;
  logic            dio_pull;

  line_levels_t line_levels_q [$];
  int           fail_cnt;
  int           live_cnt;

  // byte on the wire for the current stage and byte slot
  function automatic logic [7:0] byte_to_send();
    logic [2:0] slot_m1;
    slot_m1 = byte_idx - 3'd1;
    if (stage == ssw_pkg::STG_DATA)
      return regs.data_cmd;
    if (stage == ssw_pkg::STG_ADDR) begin
      if (byte_idx == 3'd0)
        return regs.addr_cmd + {6'd0, pos_latch};
      if (byte_idx <= MAX_SEGMENTS)
        return seg_bytes[slot_m1[1:0]];
      return 8'h00;
    end
    return regs.ctrl_cmd + {4'd0, regs.brightness};
  endfunction

  // line change made at the start of the current step
  function automatic void drive_lines(input logic sense);
    if (bit_idx == ssw_pkg::SLOT_START) begin
      dio_pull = 1'b1;
    end else if (bit_idx <= ssw_pkg::SLOT_DATA_END) begin
      unique case (step_idx)
        3'd0: clk_pull = 1'b1;
        3'd1: dio_pull = ~shifter[0];
        default: clk_pull = 1'b0;
      endcase
    end else if (bit_idx == ssw_pkg::SLOT_ACK) begin
      unique case (step_idx)
        3'd0: begin
          clk_pull = 1'b1;
          dio_pull = 1'b0;
        end
        3'd1: clk_pull = 1'b0;
        3'd2: if (!sense) dio_pull = 1'b1;
        default: clk_pull = 1'b1;
      endcase
    end else begin
      unique case (step_idx)
        3'd0: dio_pull = 1'b1;
        3'd1: clk_pull = 1'b0;
        default: dio_pull = 1'b0;
      endcase
    end
  endfunction

  // move to the next step once a delay has run out
  function automatic void next_step();
    if (bit_idx == ssw_pkg::SLOT_START) begin
      bit_idx = 4'd1;
      step_idx = 3'd0;
      byte_idx = 3'd0;
      shifter = byte_to_send();
    end else if (bit_idx <= ssw_pkg::SLOT_DATA_END) begin
      step_idx = step_idx + 3'd1;
      if (step_idx >= 3'd3) begin
        step_idx = 3'd0;
        shifter = shifter >> 1;
        bit_idx = bit_idx + 4'd1;
      end
    end else if (bit_idx == ssw_pkg::SLOT_ACK) begin
      step_idx = step_idx + 3'd1;
      if (step_idx >= 3'd4) begin
        step_idx = 3'd0;
        if (stage == ssw_pkg::STG_ADDR && byte_idx < seg_total) begin
          byte_idx = byte_idx + 3'd1;
          shifter = byte_to_send();
          bit_idx = 4'd1;
        end else begin
          bit_idx = ssw_pkg::SLOT_STOP;
        end
      end
    end else begin
      step_idx = step_idx + 3'd1;
      if (step_idx >= 3'd3) begin
        step_idx = 3'd0;
        byte_idx = 3'd0;
        bit_idx = ssw_pkg::SLOT_START;
        unique case (stage)
          ssw_pkg::STG_DATA: stage = ssw_pkg::STG_ADDR;
          ssw_pkg::STG_ADDR: stage = ssw_pkg::STG_CTRL;
          default: stage = ssw_pkg::STG_IDLE;
        endcase
      end
    end
  endfunction

  // line levels after one input beat
  function automatic line_levels_t step_writer(input ssw_pkg::op_t beat);
    logic [7:0]   limit;
    line_levels_t lv;
    if (beat.kind == ssw_pkg::OP_SEND) begin
      if (stage == ssw_pkg::STG_IDLE) begin
        seg_bytes[0] = beat.digits[0];
        seg_bytes[1] = beat.digits[1];
        seg_bytes[2] = beat.digits[2];
        seg_bytes[3] = beat.digits[3];
        seg_total = (beat.count > MAX_SEGMENTS) ? MAX_SEGMENTS : beat.count;
        pos_latch = beat.position;
        stage = ssw_pkg::STG_DATA;
        byte_idx = 3'd0;
        bit_idx = ssw_pkg::SLOT_START;
        step_idx = 3'd0;
        shifter = 8'h00;
        tick_cnt = 8'h00;
        drive_lines(beat.sense);
      end
    end else if (stage != ssw_pkg::STG_IDLE) begin
      limit = (regs.ticks == 8'd0) ? 8'd1 : regs.ticks;
      tick_cnt = tick_cnt + 8'd1;
      if (tick_cnt >= limit) begin
        tick_cnt = 8'h00;
        next_step();
        if (stage != ssw_pkg::STG_IDLE)
          drive_lines(beat.sense);
      end
    end
    lv.clk_low = clk_pull;
    lv.dio_low = dio_pull;
    lv.busy = (stage != ssw_pkg::STG_IDLE);
    return lv;
  endfunction

  function automatic void check_field(input string field, input logic want, input logic got);
    if (got !== want) begin
      fail_cnt++;
      $display("%0t: %s mismatch, expected %0b, got %0b", $time, field, want, got);
    end
  endfunction

  // watch config writes, result beats and input beats on each edge
  always @(posedge clk) begin : watch
    ssw_pkg::op_t beat;
    line_levels_t want;
    if (!rst_n) begin
      regs.brightness = 4'd15;
      regs.ticks = 8'd100;
      regs.data_cmd = 8'h40;
      regs.addr_cmd = 8'hC0;
      regs.ctrl_cmd = 8'h80;
      seg_bytes[0] = 8'h00;
      seg_bytes[1] = 8'h00;
      seg_bytes[2] = 8'h00;
      seg_bytes[3] = 8'h00;
      seg_total = 3'd0;
      pos_latch = 2'd0;
      stage = ssw_pkg::STG_IDLE;
      byte_idx = 3'd0;
      bit_idx = ssw_pkg::SLOT_START;
      step_idx = 3'd0;
      shifter = 8'h00;
      tick_cnt = 8'h00;
      clk_pull = 1'b0;
      dio_pull = 1'b0;
      line_levels_q.delete();
      fail_cnt = 0;
      live_cnt = 0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ssw_pkg::CFG_BRIGHTNESS: regs.brightness = cfg_data[3:0];
          ssw_pkg::CFG_TICKS:      regs.ticks = cfg_data;
          ssw_pkg::CFG_DATA_CMD:   regs.data_cmd = cfg_data;
          ssw_pkg::CFG_ADDR_CMD:   regs.addr_cmd = cfg_data;
          ssw_pkg::CFG_CTRL_CMD:   regs.ctrl_cmd = cfg_data;
          default: ;
        endcase
      end
      // result beat against the oldest expectation
      if (out_mon.valid && out_mon.ready) begin
        if (line_levels_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: result beat with nothing expected, got clk_low %0b dio_low %0b busy %0b",
                   $time, out_mon.clk_low, out_mon.dio_low, out_mon.busy_res);
        end else begin
          want = line_levels_q.pop_front();
          check_field("clk_low", want.clk_low, out_mon.clk_low);
          check_field("dio_low", want.dio_low, out_mon.dio_low);
          check_field("busy_res", want.busy, out_mon.busy_res);
        end
      end
      // input beat: note whether it does anything, then predict
      if (in_mon.valid && in_mon.ready) begin
        beat.kind = ssw_pkg::op_kind_t'(in_mon.command);
        beat.digits = {in_mon.digit3, in_mon.digit2, in_mon.digit1, in_mon.digit0};
        beat.count = in_mon.digit_count;
        beat.position = in_mon.first_position;
        beat.sense = in_mon.dio_sense;
        if ((beat.kind == ssw_pkg::OP_SEND) == (stage == ssw_pkg::STG_IDLE))
          live_cnt++;
        line_levels_q.push_back(step_writer(beat));
      end
    end
    fail_count <= fail_cnt;
    pending_results <= line_levels_q.size();
    live_beats <= live_cnt;
    writer_idle <= (stage == ssw_pkg::STG_IDLE);
  end

endmodule

// ===== dv/segment_display_serial_writer_tb.sv =====
// top of the segment display writer testbench: clock, reset, stimulus and verdict
// depends on ssw_pkg, ssw_in_if, ssw_out_if, the block and segment_display_serial_writer_checker
`timescale 1ns / 1ps
module segment_display_serial_writer_tb;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [ssw_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0]                    cfg_data;
  int                            fail_count;
  int                            pending_results;
  int                            live_beats;
  logic                          writer_idle;

  ssw_in_if  in_bus ();
  ssw_out_if out_bus ();

  segment_display_serial_writer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  segment_display_serial_writer_checker line_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_bus),
    .out_mon         (out_bus),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .live_beats      (live_beats),
    .writer_idle     (writer_idle)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the handshakes hang
  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

  function automatic ssw_pkg::op_t make_beat(input ssw_pkg::op_kind_t kind,
                                             input logic [31:0] digits,
                                             input logic [2:0] count, input logic [1:0] pos,
                                             input logic sense);
    ssw_pkg::op_t b;
    b.kind = kind;
    b.digits = digits;
    b.count = count;
    b.position = pos;
    b.sense = sense;
    return b;
  endfunction

  // mostly a send when idle and ticks while a frame runs, with some noise
  function automatic ssw_pkg::op_t random_beat(input logic idle_now);
    ssw_pkg::op_t b;
    int           pick;
    pick = $urandom_range(0, 99);
    b.kind = (idle_now ? pick < 85 : pick < 3) ? ssw_pkg::OP_SEND : ssw_pkg::OP_TICK;
    b.digits = $urandom;
    if ($urandom_range(0, 5) == 0)
      b.digits[2'($urandom_range(0, 3))] = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
    b.count = 3'($urandom_range(0, 7));
    b.position = 2'($urandom_range(0, 3));
    b.sense = 1'($urandom_range(0, 1));
    return b;
  endfunction

  // offer one beat and wait for it to be taken
  task automatic put_beat(input ssw_pkg::op_t b);
    in_bus.valid <= 1'b1;
    in_bus.command <= b.kind;
    in_bus.digit0 <= b.digits[0];
    in_bus.digit1 <= b.digits[1];
    in_bus.digit2 <= b.digits[2];
    in_bus.digit3 <= b.digits[3];
    in_bus.digit_count <= b.count;
    in_bus.first_position <= b.position;
    in_bus.dio_sense <= b.sense;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ssw_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [3:0] bright, input logic [7:0] ticks,
                              input logic [7:0] dcmd, input logic [7:0] acmd,
                              input logic [7:0] ccmd);
    write_reg(ssw_pkg::CFG_BRIGHTNESS, {4'd0, bright});
    write_reg(ssw_pkg::CFG_TICKS, ticks);
    write_reg(ssw_pkg::CFG_DATA_CMD, dcmd);
    write_reg(ssw_pkg::CFG_ADDR_CMD, acmd);
    write_reg(ssw_pkg::CFG_CTRL_CMD, ccmd);
    cfg_we <= 1'b0;
  endtask

  // hold the sender until every result is back, plus the pipeline depth
  task automatic drain();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (4) @(posedge clk);
  endtask

  // bursts of random beats with random gaps until enough beats did work
  task automatic run_random(input int goal);
    int burst;
    int gap;
    while (live_beats < goal) begin
      burst = $urandom_range(1, 48);
      repeat (burst) put_beat(random_beat(writer_idle));
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 10);
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // receiver: stall patterns per window, plus two long hold-offs
  initial begin
    int mode;
    int span;
    bit held_early;
    bit held_late;
    held_early = 1'b0;
    held_late = 1'b0;
    out_bus.ready <= 1'b0;
    repeat (9) @(posedge clk);
    forever begin
      if ((!held_early && live_beats >= 150) || (!held_late && live_beats >= 1200)) begin
        if (live_beats >= 1200)
          held_late = 1'b1;
        else
          held_early = 1'b1;
        out_bus.ready <= 1'b0;
        repeat (250) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 64);
      repeat (span) begin
        case (mode)
          0: out_bus.ready <= 1'b1;
          1: out_bus.ready <= 1'($urandom_range(0, 1));
          2: out_bus.ready <= ($urandom_range(0, 3) == 0);
          default: out_bus.ready <= ($urandom_range(0, 9) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // stimulus and verdict
  initial begin
    int waited;
    int goal;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= ssw_pkg::CFG_BRIGHTNESS;
    cfg_data <= 8'h00;
    in_bus.valid <= 1'b0;
    in_bus.command <= ssw_pkg::OP_TICK;
    in_bus.digit0 <= 8'h00;
    in_bus.digit1 <= 8'h00;
    in_bus.digit2 <= 8'h00;
    in_bus.digit3 <= 8'h00;
    in_bus.digit_count <= 3'd0;
    in_bus.first_position <= 2'd0;
    in_bus.dio_sense <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: address and control commands wrap, fastest timing
    program_regs(4'd15, 8'd1, 8'h40, 8'hFF, 8'hFF);
    // ticks while idle change nothing
    put_beat(make_beat(ssw_pkg::OP_TICK, 32'h0000_0000, 3'd0, 2'd0, 1'b0));
    put_beat(make_beat(ssw_pkg::OP_TICK, 32'hFFFF_FFFF, 3'd7, 2'd3, 1'b1));
    // oversized count saturates, top position
    put_beat(make_beat(ssw_pkg::OP_SEND, {8'h5A, 8'hA5, 8'h00, 8'hFF}, 3'd7, 2'd3, 1'b0));
    // send during a frame is dropped
    put_beat(make_beat(ssw_pkg::OP_SEND, 32'h0000_0000, 3'd0, 2'd0, 1'b1));
    for (int k = 0; k < 19; k++)
      put_beat(make_beat(ssw_pkg::OP_TICK, 32'h0000_0000, 3'd0, 2'd0, k[0]));

    // random phases; register sets change between them, often mid-frame
    for (int p = 1; p <= 5; p++) begin
      drain();
      case (p)
        1: begin
          // zero delay behaves as one tick
          program_regs(4'd0, 8'd0, 8'h00, 8'hC0, 8'h80);
          goal = 420;
        end
        2: begin
          program_regs(4'd7, 8'd255, 8'hFF, 8'h00, 8'h00);
          goal = 700;
        end
        3: begin
          program_regs(4'd15, 8'd2, 8'h44, 8'hFE, 8'hF8);
          goal = 1100;
        end
        4: begin
          program_regs(4'($urandom), 8'd1, 8'($urandom), 8'($urandom), 8'($urandom));
          goal = 1400;
        end
        default: begin
          program_regs(4'($urandom), 8'($urandom_range(1, 4)), 8'($urandom),
                       8'($urandom), 8'($urandom));
          goal = 1720;
        end
      endcase
      run_random(goal);
    end

    // wait out the remaining results, then watch for strays before the verdict
    in_bus.valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending_results != 0 && waited < 20000);
    if (pending_results != 0) begin
      $display("FAILURE");
      $finish;
    end else begin
      repeat (8) @(posedge clk);
      if (fail_count == 0) begin
        $display("SUCCESS");
      end else begin
        $display("FAILURE");
      end
      $finish;
    end
  end

endmodule
